FILE: rtl/sec_pkg.sv
package sec_pkg;

	localparam int VERT_W           = 8;
	localparam int COUNT_W          = 16;
	localparam int HIT_W            = 2;
	localparam int WORD_W           = 64;
	localparam int BIT_W            = 6;
	localparam int DEF_MAX_VERTICES = 256;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [1:0]         EDGE_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD1,
		ST_CK1,
		ST_WR2,
		ST_DONE
	} walk_state_t;

	typedef struct packed {
		logic              valid;
		logic [VERT_W-1:0] va;
		logic [VERT_W-1:0] vb;
		logic [VERT_W-1:0] vc;
		logic              new_mesh;
	} walk_req_t;

	typedef struct packed {
		logic             done;
		logic [HIT_W-1:0] hits;
	} walk_rsp_t;

endpackage

FILE: rtl/shared_edge_counter.sv
// Shared edge counter.
// Input channel (in_valid/in_ready) takes one triangle per request: three
// vertex indices plus new_mesh and last_triangle flags. Output channel
// (out_valid/out_ready) returns one result per request: the cumulative,
// saturating shared_count, new_shared for this triangle and mesh_done.
// Edges are held in a symmetric bit matrix stored as 64-bit words in one
// synchronous RAM; each in-range edge is a read, a check and up to two writes.
// Per request: accept, then per edge skip it if an endpoint is out of
// range, stop after the check if already seen, else write both mirror
// bits; then hand the result to the output register.
// A request with new_mesh set first sweeps the RAM clear, one word per
// cycle (MAX_VERTICES*MAX_VERTICES/64 words, 1024 at 256 vertices).
// After reset the same sweep runs while in_ready stays low.
// The output register holds a result while out_ready is low; one more
// request may be walked meanwhile, and its result waits in the walker
// until the output register frees up.
module shared_edge_counter import sec_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VERT_W-1:0]  vertex_a,
	input  logic [VERT_W-1:0]  vertex_b,
	input  logic [VERT_W-1:0]  vertex_c,
	input  logic               new_mesh,
	input  logic               last_triangle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] shared_count,
	output logic [HIT_W-1:0]   new_shared,
	output logic               mesh_done
);

	walk_req_t          req;
	walk_rsp_t          rsp;
	logic               idle, in_fire, ack;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] count_next;

	assign in_ready  = idle;
	assign in_fire   = in_valid && in_ready;
	assign req.valid    = in_valid;
	assign req.va       = vertex_a;
	assign req.vb       = vertex_b;
	assign req.vc       = vertex_c;
	assign req.new_mesh = new_mesh;

	assign ack        = rsp.done && (!out_valid || out_ready);
	assign sum        = {1'b0, count_q} + (COUNT_W + 1)'(rsp.hits);
	assign count_next = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

	sec_walk #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ack   (ack),
		.idle  (idle),
		.rsp   (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire && new_mesh) begin
				count_q <= '0;
			end else if (ack) begin
				count_q <= count_next;
			end
			if (ack) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q <= last_triangle;
		end
		if (ack) begin
			shared_count <= count_next;
			new_shared   <= rsp.hits;
			mesh_done    <= last_q;
		end
	end

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && new_mesh) |=> count_q >= $past(count_q))
		else $error("shared count decreased without new mesh");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !rsp.done && !ack)
		else $error("request accepted while a result is pending");

endmodule

FILE: rtl/sec_ram.sv
module sec_ram import sec_pkg::*; #(
	parameter int WIDTH = WORD_W,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/sec_walk.sv
module sec_walk import sec_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  walk_req_t req,
	input  logic      ack,
	output logic      idle,
	output walk_rsp_t rsp
);

	localparam int EDGE_BITS = MAX_VERTICES * MAX_VERTICES;
	localparam int WORDS     = (EDGE_BITS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int POS_W     = ADDR_W + BIT_W;

	walk_state_t state_q, state_d;
	logic [1:0]        edge_q, edge_d;
	logic [HIT_W-1:0]  hits_q, hits_d;
	logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
	logic              run_q, run_d;
	logic [VERT_W-1:0] va_q, vb_q, vc_q;
	logic [ADDR_W-1:0] addr1_q, addr2_q;
	logic [BIT_W-1:0]  bit1_q, bit2_q;
	logic [WORD_W-1:0] wdata1_q;

	logic [VERT_W-1:0] row, col;
	logic              in_range;
	logic [POS_W-1:0]  pos1, pos2;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata, word2;
	logic              load, last_edge;

	always_comb begin
		unique case (edge_q)
			2'd0:    begin row = va_q; col = vb_q; end
			2'd1:    begin row = vb_q; col = vc_q; end
			default: begin row = vc_q; col = va_q; end
		endcase
	end

	assign in_range  = (32'(row) < MAX_VERTICES) && (32'(col) < MAX_VERTICES);
	assign pos1      = POS_W'(32'(col) * MAX_VERTICES + 32'(row));
	assign pos2      = POS_W'(32'(row) * MAX_VERTICES + 32'(col));
	assign word2     = (addr2_q == addr1_q) ? wdata1_q : mem_rdata;
	assign last_edge = (edge_q == EDGE_LAST);

	sec_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		state_d    = state_q;
		edge_d     = edge_q;
		hits_d     = hits_q;
		clr_addr_d = clr_addr_q;
		run_d      = run_q;
		load       = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = addr1_q;
		mem_wdata  = mem_rdata | (WORD_W'(1) << bit1_q);
		mem_raddr  = pos1[POS_W-1:BIT_W];
		idle       = 1'b0;
		rsp.done   = 1'b0;
		rsp.hits   = hits_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we     = 1'b1;
				mem_waddr  = clr_addr_q;
				mem_wdata  = '0;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(WORDS - 1)) begin
					clr_addr_d = '0;
					run_d      = 1'b0;
					state_d    = run_q ? ST_RD1 : ST_IDLE;
				end
			end
			ST_IDLE: begin
				idle = 1'b1;
				if (req.valid) begin
					load    = 1'b1;
					edge_d  = '0;
					hits_d  = '0;
					run_d   = req.new_mesh;
					state_d = req.new_mesh ? ST_CLEAR : ST_RD1;
				end
			end
			ST_RD1: begin
				if (in_range) begin
					state_d = ST_CK1;
				end else if (last_edge) begin
					state_d = ST_DONE;
				end else begin
					edge_d = edge_q + 1'b1;
				end
			end
			ST_CK1: begin
				mem_raddr = addr2_q;
				if (mem_rdata[bit1_q]) begin
					hits_d  = hits_q + 1'b1;
					state_d = last_edge ? ST_DONE : ST_RD1;
					edge_d  = last_edge ? edge_q : edge_q + 1'b1;
				end else begin
					mem_we  = 1'b1;
					state_d = ST_WR2;
				end
			end
			ST_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = addr2_q;
				mem_wdata = word2 | (WORD_W'(1) << bit2_q);
				state_d   = last_edge ? ST_DONE : ST_RD1;
				edge_d    = last_edge ? edge_q : edge_q + 1'b1;
			end
			ST_DONE: begin
				rsp.done = 1'b1;
				if (ack) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			edge_q     <= '0;
			hits_q     <= '0;
			clr_addr_q <= '0;
			run_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			edge_q     <= edge_d;
			hits_q     <= hits_d;
			clr_addr_q <= clr_addr_d;
			run_q      <= run_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			va_q <= req.va;
			vb_q <= req.vb;
			vc_q <= req.vc;
		end
		if (state_q == ST_RD1) begin
			addr1_q <= pos1[POS_W-1:BIT_W];
			bit1_q  <= pos1[BIT_W-1:0];
			addr2_q <= pos2[POS_W-1:BIT_W];
			bit2_q  <= pos2[BIT_W-1:0];
		end
		if (state_q == ST_CK1) begin
			wdata1_q <= mem_wdata;
		end
	end

	a_done_last_edge: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> edge_q == EDGE_LAST)
		else $error("walk finished before the last edge");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !mem_we)
		else $error("matrix written outside a walk");

	a_miss_sets_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR2 |-> $past(state_q) == ST_CK1 && $past(mem_we))
		else $error("mirror write without first write");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> mem_we && mem_wdata == '0)
		else $error("clear pass wrote nonzero data");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import sec_pkg::*;

	localparam int MAX_V = DEF_MAX_VERTICES;

	typedef struct {
		logic [COUNT_W-1:0] count;
		logic [HIT_W-1:0]   hits;
		logic               done;
	} tri_result_t;

	class shared_edge_tracker;
		bit [MAX_V*MAX_V-1:0] seen;
		logic [COUNT_W-1:0]   total;
		tri_result_t          pending_results[$];
		int                   errors;

		function new();
			seen = '0;
			total = '0;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function int unsigned walk_edge(int unsigned r, int unsigned c);
			if (r >= MAX_V || c >= MAX_V) begin
				return 0;
			end
			if (seen[c*MAX_V + r]) begin
				return 1;
			end
			seen[c*MAX_V + r] = 1'b1;
			seen[r*MAX_V + c] = 1'b1;
			return 0;
		endfunction

		function void note_triangle(input logic [VERT_W-1:0] a, b, c, input logic fresh, last);
			int unsigned v[3];
			int unsigned hits;
			int unsigned h;
			tri_result_t r;
			v[0] = 32'(a);
			v[1] = 32'(b);
			v[2] = 32'(c);
			if (fresh) begin
				seen = '0;
				total = '0;
			end
			hits = 0;
			for (int k = 0; k < 3; k++) begin
				h = walk_edge(v[k], v[(k+1)%3]);
				hits += h;
				if (h != 0 && total != COUNT_MAX) begin
					total++;
				end
			end
			r.count = total;
			r.hits = hits[HIT_W-1:0];
			r.done = last;
			pending_results.push_back(r);
		endfunction

		function void check_result(input logic [COUNT_W-1:0] count,
				input logic [HIT_W-1:0] hits, input logic done);
			tri_result_t e;
			if (pending_results.size() == 0) begin
				flag($sformatf("unexpected result: count %0d hits %0d done %0d",
					count, hits, done));
				return;
			end
			e = pending_results.pop_front();
			if (count !== e.count) begin
				flag($sformatf("shared_count mismatch: expected %0d, got %0d", e.count, count));
			end
			if (hits !== e.hits) begin
				flag($sformatf("new_shared mismatch: expected %0d, got %0d", e.hits, hits));
			end
			if (done !== e.done) begin
				flag($sformatf("mesh_done mismatch: expected %0d, got %0d", e.done, done));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VERT_W-1:0]  vertex_a = '0;
	logic [VERT_W-1:0]  vertex_b = '0;
	logic [VERT_W-1:0]  vertex_c = '0;
	logic               new_mesh = 1'b0;
	logic               last_triangle = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] shared_count;
	logic [HIT_W-1:0]   new_shared;
	logic               mesh_done;

	int                 send_idle = 0;
	int                 recv_stall = 0;
	int                 sent_items = 0;
	shared_edge_tracker tracker = new();

	shared_edge_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.vertex_c     (vertex_c),
		.new_mesh     (new_mesh),
		.last_triangle(last_triangle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.shared_count (shared_count),
		.new_shared   (new_shared),
		.mesh_done    (mesh_done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			tracker.check_result(shared_count, new_shared, mesh_done);
		end
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_triangle(input logic [VERT_W-1:0] a, b, c, input logic fresh, last);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		vertex_a <= a;
		vertex_b <= b;
		vertex_c <= c;
		new_mesh <= fresh;
		last_triangle <= last;
		do @(posedge clk); while (!in_ready);
		tracker.note_triangle(a, b, c, fresh, last);
		sent_items++;
	endtask

	task automatic random_mesh();
		int unsigned len;
		int unsigned base;
		int unsigned span;
		logic [VERT_W-1:0] v[3];
		logic fresh;
		logic last;
		bit noise;
		len = $urandom_range(60, 8);
		base = $urandom_range(255);
		span = $urandom_range(12, 2);
		for (int i = 0; i < len; i++) begin
			noise = ($urandom_range(99) < 8);
			for (int j = 0; j < 3; j++) begin
				if (noise || $urandom_range(99) < 10) begin
					v[j] = VERT_W'($urandom_range(255));
				end else begin
					v[j] = VERT_W'(base + $urandom_range(span));
				end
			end
			fresh = (i == 0);
			last = (i == len - 1);
			if (noise) begin
				fresh = 1'($urandom_range(1));
				last = 1'($urandom_range(1));
			end
			send_triangle(v[0], v[1], v[2], fresh, last);
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int items);
		int start;
		start = sent_items;
		send_idle = idle;
		recv_stall = stall;
		while (sent_items - start < items) begin
			random_mesh();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_triangle(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
		send_triangle(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
		send_triangle(8'd0, 8'd255, 8'd128, 1'b0, 1'b0);
		send_triangle(8'd255, 8'd128, 8'd0, 1'b0, 1'b0);
		send_triangle(8'd128, 8'd0, 8'd255, 1'b0, 1'b0);
		send_triangle(8'd1, 8'd2, 8'd3, 1'b0, 1'b0);
		send_triangle(8'd3, 8'd2, 8'd1, 1'b0, 1'b1);
		send_triangle(8'd0, 8'd255, 8'd128, 1'b1, 1'b0);
		send_triangle(8'd0, 8'd1, 8'd0, 1'b0, 1'b0);
		send_triangle(8'd170, 8'd85, 8'd170, 1'b0, 1'b0);
		send_triangle(8'd85, 8'd170, 8'd85, 1'b0, 1'b0);
		send_triangle(8'd255, 8'd0, 8'd1, 1'b1, 1'b1);
		send_triangle(8'd1, 8'd255, 8'd0, 1'b0, 1'b1);

		// repeat one triangle so all its edges count as shared
		send_triangle(8'd10, 8'd20, 8'd30, 1'b1, 1'b0);
		repeat (20) send_triangle(8'd10, 8'd20, 8'd30, 1'b0, 1'b0);
		repeat (4) send_triangle(8'd30, 8'd20, 8'd10, 1'b0, 1'b0);
		send_triangle(8'd10, 8'd20, 8'd30, 1'b0, 1'b1);

		run_phase(0, 0, 275);
		run_phase(70, 0, 275);
		run_phase(0, 70, 275);
		run_phase(20, 20, 275);

		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
